>>> design/mfvs_pkg.sv
// mfvs_pkg: shared types and constants of the multi-format value scan
// used by every module of the block; no dependencies

package mfvs_pkg;

  localparam int POS_BITS   = 25;
  localparam int LIMIT_BITS = 18;
  localparam int TGT_BITS   = 33;
  localparam int KIND_BITS  = 3;
  localparam int SLOTS      = 4;
  localparam int KINDS      = 6;
  localparam int CFG_IDX_BITS = 1;

  localparam logic [POS_BITS-1:0]   POS_MAX     = {POS_BITS{1'b1}};
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 18'd200000;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_TARGET = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LIMIT  = 1'b1;

  // reading kinds, also the bit index within a slot's hit vector
  localparam int KIND_U8   = 0;
  localparam int KIND_S8   = 1;
  localparam int KIND_BE16 = 2;
  localparam int KIND_LE16 = 3;
  localparam int KIND_BE32 = 4;
  localparam int KIND_LE32 = 5;

  typedef struct packed {
    logic [31:0] value;
    logic        u8_ok;
    logic        s8_ok;
    logic        u16_ok;
    logic        u32_ok;
  } tgt_t;

  typedef struct packed {
    logic [SLOTS-1:0][KINDS-1:0] hits;
    logic [POS_BITS-1:0]         base;
    logic                        last;
  } entry_t;

endpackage

>>> design/mfvs_cfg.sv
// mfvs_cfg: target and limit registers with the range decode of the target
// depends on mfvs_pkg

module mfvs_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [mfvs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [mfvs_pkg::TGT_BITS-1:0]      cfg_wdata,
  output mfvs_pkg::tgt_t                     tgt,
  output logic [mfvs_pkg::LIMIT_BITS-1:0]    limit
);
  import mfvs_pkg::*;

  logic [TGT_BITS-1:0]   target_r;
  logic [LIMIT_BITS-1:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      limit_r  <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TARGET: target_r <= cfg_wdata;
        REG_LIMIT:  limit_r  <= cfg_wdata[LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    tgt.value  = target_r[31:0];
    tgt.u8_ok  = ~|target_r[32:8];
    tgt.s8_ok  = (~|target_r[32:7]) | (&target_r[32:7]);
    tgt.u16_ok = ~|target_r[32:16];
    tgt.u32_ok = ~target_r[32];
  end

  assign limit = limit_r;

endmodule

>>> design/mfvs_judge.sv
// mfvs_judge: look-behind window, byte position and the per-offset reading compare
// depends on mfvs_pkg; feeds one hit entry per byte to mfvs_serial

module mfvs_judge (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_byte,
  input  logic                 in_final,
  input  mfvs_pkg::tgt_t       tgt,
  output logic                 entry_valid,
  output mfvs_pkg::entry_t     entry,
  input  logic                 entry_take
);
  import mfvs_pkg::*;

  logic [2:0][7:0]     win_r, win_nxt;
  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic                entry_valid_r;
  entry_t              entry_r, entry_nxt;
  logic                accept;
  logic                ge3;
  logic [2:0]          n;
  logic [4:0][7:0]     bufx;

  assign in_ready = !entry_valid_r || entry_take;
  assign accept   = in_valid && in_ready;
  assign ge3      = pos_r >= POS_BITS'(3);

  always_comb begin
    logic en;
    logic ok16;
    logic [7:0] b0;
    logic [7:0] b1;
    bufx = '0;
    if (ge3) begin
      bufx[0] = win_r[2]; bufx[1] = win_r[1]; bufx[2] = win_r[0]; bufx[3] = in_byte;
      n = 3'd4;
    end else begin
      case (pos_r[1:0])
        2'd2: begin
          bufx[0] = win_r[1]; bufx[1] = win_r[0]; bufx[2] = in_byte;
        end
        2'd1: begin
          bufx[0] = win_r[0]; bufx[1] = in_byte;
        end
        default: begin
          bufx[0] = in_byte;
        end
      endcase
      n = 3'(pos_r[1:0]) + 3'd1;
    end
    entry_nxt.base = pos_r - POS_BITS'(n - 3'd1);
    entry_nxt.last = in_final;
    entry_nxt.hits = '0;
    for (int j = 0; j < SLOTS; j++) begin
      en   = in_final ? (3'(j) < n) : (j == 0 && ge3);
      ok16 = (3'(j) + 3'd2) <= n;
      b0   = bufx[j];
      b1   = bufx[j+1];
      entry_nxt.hits[j][KIND_U8]   = en && tgt.u8_ok && b0 == tgt.value[7:0];
      entry_nxt.hits[j][KIND_S8]   = en && tgt.s8_ok && b0 == tgt.value[7:0];
      entry_nxt.hits[j][KIND_BE16] = en && ok16 && tgt.u16_ok && {b0, b1} == tgt.value[15:0];
      entry_nxt.hits[j][KIND_LE16] = en && ok16 && tgt.u16_ok && {b1, b0} == tgt.value[15:0];
    end
    entry_nxt.hits[0][KIND_BE32] = (in_final || ge3) && n == 3'd4 && tgt.u32_ok &&
                                   {bufx[0], bufx[1], bufx[2], bufx[3]} == tgt.value;
    entry_nxt.hits[0][KIND_LE32] = (in_final || ge3) && n == 3'd4 && tgt.u32_ok &&
                                   {bufx[3], bufx[2], bufx[1], bufx[0]} == tgt.value;
  end

  always_comb begin
    win_nxt = win_r;
    pos_nxt = pos_r;
    if (accept) begin
      if (in_final) begin
        win_nxt = '0;
        pos_nxt = '0;
      end else begin
        win_nxt = {win_r[1], win_r[0], in_byte};
        if (pos_r != POS_MAX) begin
          pos_nxt = pos_r + POS_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r         <= '0;
      pos_r         <= '0;
      entry_valid_r <= 1'b0;
    end else begin
      win_r <= win_nxt;
      pos_r <= pos_nxt;
      if (accept) begin
        entry_valid_r <= 1'b1;
      end else if (entry_take) begin
        entry_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      entry_r <= entry_nxt;
    end
  end

  assign entry_valid = entry_valid_r;
  assign entry       = entry_r;

endmodule

>>> design/mfvs_serial.sv
// mfvs_serial: walks each hit entry in offset then kind order, applies the limit,
// adds the summary and holds the result register; depends on mfvs_pkg

module mfvs_serial #(
  parameter int OFFSET_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              entry_valid,
  input  mfvs_pkg::entry_t                  entry,
  output logic                              entry_take,
  input  logic [mfvs_pkg::LIMIT_BITS-1:0]   limit,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [OFFSET_BITS-1:0]            out_offset,
  output logic [mfvs_pkg::KIND_BITS-1:0]    out_kind,
  output logic                              out_summary,
  output logic [mfvs_pkg::LIMIT_BITS-1:0]   out_total,
  output logic                              out_last
);
  import mfvs_pkg::*;

  logic                              cur_valid_r;
  entry_t                            cur_r;
  logic [LIMIT_BITS-1:0]             count_r;
  logic                              out_valid_r;
  logic [OFFSET_BITS-1:0]            out_offset_r;
  logic [KIND_BITS-1:0]              out_kind_r;
  logic                              out_summary_r;
  logic [LIMIT_BITS-1:0]             out_total_r;
  logic                              out_last_r;

  logic [1:0]                        sel_slot;
  logic [KIND_BITS-1:0]              sel_kind;
  logic [SLOTS-1:0][KINDS-1:0]       clr, hits_rest;
  logic                              can_out, allowed, has_match, has_sum;
  logic                              more, match_last, emit, cur_done, load;
  logic [POS_BITS:0]                 off_sum;

  always_comb begin
    logic found;
    logic [KINDS-1:0] row;
    sel_slot = '0;
    found    = 1'b0;
    for (int j = 0; j < SLOTS; j++) begin
      if (!found && |cur_r.hits[j]) begin
        sel_slot = 2'(j);
        found    = 1'b1;
      end
    end
    row      = cur_r.hits[sel_slot];
    sel_kind = '0;
    found    = 1'b0;
    for (int k = 0; k < KINDS; k++) begin
      if (!found && row[k]) begin
        sel_kind = KIND_BITS'(k);
        found    = 1'b1;
      end
    end
    clr = '0;
    clr[sel_slot][sel_kind] = 1'b1;
    hits_rest = cur_r.hits & ~clr;
  end

  assign can_out    = !out_valid_r || out_ready;
  assign allowed    = count_r < limit;
  assign has_match  = cur_valid_r && (|cur_r.hits) && allowed;
  assign has_sum    = cur_valid_r && !has_match && cur_r.last;
  assign more       = (|hits_rest) &&
                      (({1'b0, count_r} + (LIMIT_BITS+1)'(1)) < {1'b0, limit});
  assign match_last = !more && !cur_r.last;
  assign emit       = (has_match || has_sum) && can_out;
  assign cur_done   = cur_valid_r && ((!has_match && !has_sum) ||
                      (emit && (has_sum || match_last)));
  assign load       = !cur_valid_r || cur_done;
  assign entry_take = load && entry_valid;
  assign off_sum    = {1'b0, cur_r.base} + (POS_BITS+1)'(sel_slot);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        cur_valid_r <= entry_valid;
      end
      if (emit && has_match) begin
        count_r <= count_r + LIMIT_BITS'(1);
      end else if (emit && has_sum) begin
        count_r <= '0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= entry;
    end else if (emit && has_match) begin
      cur_r.hits <= hits_rest;
    end
    if (emit) begin
      if (has_match) begin
        out_offset_r  <= OFFSET_BITS'(off_sum);
        out_kind_r    <= sel_kind;
        out_summary_r <= 1'b0;
        out_total_r   <= '0;
        out_last_r    <= match_last;
      end else begin
        out_offset_r  <= '0;
        out_kind_r    <= '0;
        out_summary_r <= 1'b1;
        out_total_r   <= count_r;
        out_last_r    <= 1'b1;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_offset  = out_offset_r;
  assign out_kind    = out_kind_r;
  assign out_summary = out_summary_r;
  assign out_total   = out_total_r;
  assign out_last    = out_last_r;

endmodule

>>> design/multi_format_value_scan.sv
// multi_format_value_scan: top level of the value scan
// depends on mfvs_pkg, mfvs_cfg, mfvs_judge and mfvs_serial
//
// memory bytes arrive on the in_ stream in ascending address order, one per
// transfer, with in_tlast on the last byte of the region. each offset is tested
// as u8, s8, be16, le16, be32 and le32 against the target register; matches
// leave on the out_ stream ordered by offset then kind, and the transfer after
// the last byte's matches is a summary (out_tuser high) carrying the count.
// out_tlast marks the last result caused by one input byte.
// an offset is judged when the byte three places later arrives, so a match
// leaves 3 bytes after its own byte plus its way through the entry register,
// walk register and result register. bytes are taken one per cycle while
// each byte causes at most one result and the receiver is ready; a byte with
// several results holds the walk until they have all left; the final byte can cause up to 17.
// a stalled receiver holds the result register, then the walk, then the
// entry register, and only then drops in_tready.
// reset clears the window, position, count and pipeline and sets the limit
// to 200000 and the target to zero; taking the final byte clears window and position,
// and its summary clears the count. configuration writes are taken at once on cfg_we.

module multi_format_value_scan #(
  parameter int OFFSET_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // data_byte
  input  logic                               in_tlast,   // final_byte
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [((OFFSET_BITS+21+7)/8)*8-1:0] out_tdata, // match_offset, match_kind, match_total
  output logic                               out_tuser,  // summary_item
  output logic                               out_tlast,  // run_last
  input  logic                               cfg_we,
  input  logic [mfvs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [mfvs_pkg::TGT_BITS-1:0]      cfg_wdata
);
  import mfvs_pkg::*;

  localparam int TDATA_W = ((OFFSET_BITS + 21 + 7) / 8) * 8;
  localparam int FIELD_W = OFFSET_BITS + KIND_BITS + LIMIT_BITS;

  tgt_t                   tgt;
  logic [LIMIT_BITS-1:0]  limit;
  logic                   entry_valid;
  entry_t                 entry;
  logic                   entry_take;
  logic [OFFSET_BITS-1:0] res_offset;
  logic [KIND_BITS-1:0]   res_kind;
  logic [LIMIT_BITS-1:0]  res_total;
  logic [FIELD_W-1:0]     res_fields;

  mfvs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .tgt       (tgt),
    .limit     (limit)
  );

  mfvs_judge u_judge (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_byte     (in_tdata),
    .in_final    (in_tlast),
    .tgt         (tgt),
    .entry_valid (entry_valid),
    .entry       (entry),
    .entry_take  (entry_take)
  );

  mfvs_serial #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_serial (
    .clk         (clk),
    .rst_n       (rst_n),
    .entry_valid (entry_valid),
    .entry       (entry),
    .entry_take  (entry_take),
    .limit       (limit),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_offset  (res_offset),
    .out_kind    (res_kind),
    .out_summary (out_tuser),
    .out_total   (res_total),
    .out_last    (out_tlast)
  );

  assign res_fields = {res_total, res_kind, res_offset};
  assign out_tdata  = TDATA_W'(res_fields);

endmodule
